FILE: sv/akf_pkg.sv
// Shared types, constants and fixed-point helpers for the altitude Kalman filter.
`default_nettype none
package akf_pkg;
    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_WIDTH  = 31;
    localparam int DT_WIDTH   = 19;
    localparam int IDX_WIDTH  = 2;
    localparam int DIV_STEPS  = WORD_WIDTH + FRAC_BITS;
    localparam int CNT_WIDTH  = $clog2(DIV_STEPS + 1);

    typedef logic signed [WORD_WIDTH-1:0] word_t;

    localparam logic [IDX_WIDTH-1:0] REG_QP = 2'd0;
    localparam logic [IDX_WIDTH-1:0] REG_QV = 2'd1;
    localparam logic [IDX_WIDTH-1:0] REG_R  = 2'd2;

    localparam word_t WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
    localparam word_t ONE_FX   = word_t'(1) <<< FRAC_BITS;

    // Saturate a sum or difference of two words.
    function automatic word_t sat_add(input word_t a, input word_t b, input logic sub);
        logic signed [WORD_WIDTH:0] s;
        begin
            s = sub ? ({a[WORD_WIDTH-1], a} - {b[WORD_WIDTH-1], b})
                    : ({a[WORD_WIDTH-1], a} + {b[WORD_WIDTH-1], b});
            if (s[WORD_WIDTH] != s[WORD_WIDTH-1])
                sat_add = s[WORD_WIDTH] ? WORD_MIN : WORD_MAX;
            else
                sat_add = s[WORD_WIDTH-1:0];
        end
    endfunction

    // Apply a sign to a magnitude and saturate.
    function automatic word_t sign_sat(input logic [2*WORD_WIDTH-1:0] m, input logic neg);
        logic [2*WORD_WIDTH-1:0] lim;
        logic [2*WORD_WIDTH-1:0] v;
        begin
            lim = neg ? (2*WORD_WIDTH)'(WORD_MAX) + 1'b1 : (2*WORD_WIDTH)'(WORD_MAX);
            v = (m > lim) ? lim : m;
            sign_sat = neg ? word_t'(-v) : word_t'(v);
        end
    endfunction
endpackage
`default_nettype wire

FILE: sv/akf_if.sv
// Valid/ready channel interfaces for measurements and estimates.
`default_nettype none
interface akf_in_if import akf_pkg::*; ();
    logic                            valid;
    logic                            ready;
    logic signed [WORD_WIDTH-1:0]    altitude_measurement;
    logic        [DT_WIDTH-1:0]      time_step;
    modport source (output valid, altitude_measurement, time_step, input ready);
    modport sink   (input valid, altitude_measurement, time_step, output ready);
endinterface

interface akf_out_if import akf_pkg::*; ();
    logic                            valid;
    logic                            ready;
    logic signed [WORD_WIDTH-1:0]    altitude_estimate;
    logic signed [WORD_WIDTH-1:0]    climb_rate_estimate;
    modport source (output valid, altitude_estimate, climb_rate_estimate, input ready);
    modport sink   (input valid, altitude_estimate, climb_rate_estimate, output ready);
endinterface
`default_nettype wire

FILE: sv/akf_mul.sv
// Registered rounding fixed-point multiplier shared by all products.
`default_nettype none
module akf_mul import akf_pkg::*; (
    input  wire logic  clk,
    input  wire word_t a,
    input  wire word_t b,
    output word_t      p
);
    logic [WORD_WIDTH-1:0]   ma;
    logic [WORD_WIDTH-1:0]   mb;
    logic [2*WORD_WIDTH-1:0] prod;
    logic [2*WORD_WIDTH-1:0] rnd;
    word_t                   p_reg;
    word_t                   p_next;

    always_comb
    begin
        ma     = a[WORD_WIDTH-1] ? WORD_WIDTH'(-a) : WORD_WIDTH'(a);
        mb     = b[WORD_WIDTH-1] ? WORD_WIDTH'(-b) : WORD_WIDTH'(b);
        prod   = (2*WORD_WIDTH)'(ma) * (2*WORD_WIDTH)'(mb);
        rnd    = (prod + ((2*WORD_WIDTH)'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
        p_next = sign_sat(rnd, a[WORD_WIDTH-1] ^ b[WORD_WIDTH-1]);
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;
endmodule
`default_nettype wire

FILE: sv/akf_div.sv
// Restoring divider, one quotient bit per cycle, for the Kalman gains.
`default_nettype none
module akf_div import akf_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire word_t num,
    input  wire word_t den,
    output logic       done,
    output word_t      quo
);
    localparam int NW = WORD_WIDTH + FRAC_BITS;

    logic [NW-1:0]          n_reg, n_next;
    logic [NW-1:0]          q_reg, q_next;
    logic [WORD_WIDTH:0]    r_reg, r_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [WORD_WIDTH:0]    shifted;
    logic [WORD_WIDTH-1:0]  mn;

    always_comb
    begin
        n_next    = n_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        mn        = num[WORD_WIDTH-1] ? WORD_WIDTH'(-num) : WORD_WIDTH'(num);
        shifted   = {r_reg[WORD_WIDTH-1:0], n_reg[NW-1]};
        if (start)
        begin
            n_next    = {mn, {FRAC_BITS{1'b0}}};
            q_next    = '0;
            r_next    = '0;
            cnt_next  = CNT_WIDTH'(DIV_STEPS);
            neg_next  = num[WORD_WIDTH-1];
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            n_next = n_reg << 1;
            if (shifted >= {1'b0, den})
            begin
                r_next = shifted - {1'b0, den};
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_WIDTH'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo  = sign_sat((2*WORD_WIDTH)'(q_reg), neg_reg);
endmodule
`default_nettype wire

FILE: sv/altitude_kalman_filter_2state_core.sv
// Top level: sequencer around a shared multiplier and divider for the 2-state filter.
//
//  channel   dir  handshake        payload
//  in_ch     in   valid/ready      altitude_measurement, time_step
//  out_ch    out  valid/ready      altitude_estimate, climb_rate_estimate
//  cfg       in   cfg_we           cfg_index, cfg_data
//
// The estimate is offered after 11 multiplier steps, each an issue state and a
// write-back state, plus two divisions, each a start, 48 quotient bits, done and
// write-back. With a non-positive innovation variance the divisions are skipped.
// rst_n clears state to zero and covariance to identity. in_ch is not ready from
// the transfer until the estimate is taken on out_ch.
`default_nettype none
module altitude_kalman_filter_2state_core import akf_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [IDX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_WIDTH-1:0] cfg_data,
    akf_in_if.sink                    in_ch,
    akf_out_if.source                 out_ch
);
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_WB   = 7'b0000100,
        ST_DIV  = 7'b0001000,
        ST_DWT  = 7'b0010000,
        ST_DWB  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic       dsel_reg, dsel_next;

    logic [CFG_WIDTH-1:0] qp_reg, qv_reg, r_reg;
    word_t x0_reg, x1_reg, p0_reg, p1_reg, p2_reg, p3_reg;
    word_t z_reg, dt_reg, y_reg, s_reg, k0_reg, k1_reg, pp00_reg, pp10_reg;
    word_t x0_next, x1_next, p0_next, p1_next, p2_next, p3_next;
    word_t y_next, s_next, k0_next, k1_next, pp00_next, pp10_next;

    word_t ma, mb, mp, dn, dq;
    logic  dstart, ddone;

    akf_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));
    akf_div u_div (.clk(clk), .rst_n(rst_n), .start(dstart), .num(dn), .den(s_reg),
                   .done(ddone), .quo(dq));

    // Operand select for each multiplier step.
    always_comb
    begin
        ma = dt_reg;
        mb = x1_reg;
        case (step_reg)
            4'd0: begin ma = dt_reg; mb = x1_reg; end
            4'd1: begin ma = dt_reg; mb = p2_reg; end
            4'd2: begin ma = dt_reg; mb = p3_reg; end
            4'd3: begin ma = p1_reg; mb = dt_reg; end
            4'd4: begin ma = p3_reg; mb = dt_reg; end
            4'd5: begin ma = k0_reg; mb = y_reg;  end
            4'd6: begin ma = k1_reg; mb = y_reg;  end
            4'd7: begin ma = k0_reg; mb = pp00_reg; end
            4'd8: begin ma = k1_reg; mb = p1_reg; end
            4'd9: begin ma = k1_reg; mb = pp00_reg; end
            default: begin ma = k0_reg; mb = p1_reg; end
        endcase
    end

    assign dn     = dsel_reg ? pp10_reg : pp00_reg;
    assign dstart = (state_reg == ST_DIV);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        dsel_next  = dsel_reg;
        x0_next = x0_reg; x1_next = x1_reg;
        p0_next = p0_reg; p1_next = p1_reg; p2_next = p2_reg; p3_next = p3_reg;
        y_next = y_reg; s_next = s_reg; k0_next = k0_reg; k1_next = k1_reg;
        pp00_next = pp00_reg; pp10_next = pp10_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    step_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: state_next = ST_WB;
            ST_WB:
            begin
                step_next  = step_reg + 1'b1;
                state_next = ST_MUL;
                case (step_reg)
                    4'd0: x0_next = sat_add(x0_reg, mp, 1'b0);
                    4'd1: p0_next = sat_add(p0_reg, mp, 1'b0);
                    4'd2: p1_next = sat_add(p1_reg, mp, 1'b0);
                    4'd3:
                    begin
                        pp00_next = sat_add(sat_add(p0_reg, mp, 1'b0),
                                            word_t'({1'b0, qp_reg}), 1'b0);
                        p0_next   = pp00_next;
                    end
                    4'd4:
                    begin
                        pp10_next = sat_add(p2_reg, mp, 1'b0);
                        p2_next   = pp10_next;
                        p3_next   = sat_add(p3_reg, word_t'({1'b0, qv_reg}), 1'b0);
                        y_next    = sat_add(z_reg, x0_reg, 1'b1);
                        s_next    = sat_add(p0_reg, word_t'({1'b0, r_reg}), 1'b0);
                        k0_next   = '0;
                        k1_next   = '0;
                        dsel_next = 1'b0;
                        if (!s_next[WORD_WIDTH-1] && s_next != '0)
                            state_next = ST_DIV;
                    end
                    4'd5: x0_next = sat_add(x0_reg, mp, 1'b0);
                    4'd6: x1_next = sat_add(x1_reg, mp, 1'b0);
                    4'd7: p0_next = sat_add(pp00_reg, mp, 1'b1);
                    // P11 uses the predicted P01, so it goes before P01 is overwritten
                    4'd8: p3_next = sat_add(p3_reg, mp, 1'b1);
                    4'd9: p2_next = sat_add(pp10_reg, mp, 1'b1);
                    default:
                    begin
                        p1_next    = sat_add(p1_reg, mp, 1'b1);
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_DIV: state_next = ST_DWT;
            ST_DWT: if (ddone) state_next = ST_DWB;
            ST_DWB:
            begin
                if (dsel_reg)
                begin
                    k1_next    = dq;
                    state_next = ST_MUL;
                end
                else
                begin
                    k0_next    = dq;
                    dsel_next  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_OUT: if (out_ch.ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            dsel_reg  <= 1'b0;
            qp_reg    <= CFG_WIDTH'(655);
            qv_reg    <= CFG_WIDTH'(6554);
            r_reg     <= CFG_WIDTH'(65536);
            x0_reg <= '0; x1_reg <= '0;
            p0_reg <= ONE_FX; p1_reg <= '0; p2_reg <= '0; p3_reg <= ONE_FX;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            dsel_reg  <= dsel_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_QP: qp_reg <= cfg_data;
                    REG_QV: qv_reg <= cfg_data;
                    REG_R:  r_reg  <= cfg_data;
                    default: ;
                endcase
            end
            x0_reg <= x0_next; x1_reg <= x1_next;
            p0_reg <= p0_next; p1_reg <= p1_next; p2_reg <= p2_next; p3_reg <= p3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_ch.valid)
        begin
            z_reg  <= in_ch.altitude_measurement;
            dt_reg <= word_t'({1'b0, in_ch.time_step});
        end
        y_reg <= y_next; s_reg <= s_next; k0_reg <= k0_next; k1_reg <= k1_next;
        pp00_reg <= pp00_next; pp10_reg <= pp10_next;
    end

    assign in_ch.ready                = (state_reg == ST_IDLE);
    assign out_ch.valid               = (state_reg == ST_OUT);
    assign out_ch.altitude_estimate   = x0_reg;
    assign out_ch.climb_rate_estimate = x1_reg;
endmodule
`default_nettype wire

FILE: sim/akf_tb_if.sv
// Estimate record type that the testbench queues.
`timescale 1ns / 100ps
// The channel interfaces come from the RTL file list (akf_in_if, akf_out_if).
// This file holds the small record type the testbench queues.
package akf_tb_pkg;
    import akf_pkg::*;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] altitude;
        logic signed [WORD_WIDTH-1:0] climb_rate;
    } estimate_t;
endpackage

FILE: sim/tb.sv
// Testbench for the altitude Kalman filter core: directed table, register and zero-noise cases, then random updates.
`timescale 1ns / 100ps
module tb import akf_pkg::*, akf_tb_pkg::*; ();

    localparam int  N_RANDOM    = 1130;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  DRAIN_WAIT  = 200;

    typedef struct {
        logic signed [31:0] z;
        logic [18:0]        dt;
        logic               known;
        estimate_t          est;
    } vector_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IDX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0] cfg_data;

    akf_in_if  in_ch ();
    akf_out_if out_ch ();

    altitude_kalman_filter_2state_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
    );

    // predictor state, 64-bit signed holding word-range values
    longint pos_est, vel_est;
    longint cov [4];
    longint q_pos, q_vel, r_meas;

    estimate_t expected_estimates [$];
    int  errors;
    int  updates_sent;
    int  estimates_seen;
    bit  out_stall_on;
    bit  hold_output;
    longint cycles;

    localparam longint WMAXL = 64'sd2147483647;
    localparam longint WMINL = -64'sd2147483648;

    function automatic longint clamp(input longint v);
        if (v > WMAXL) return WMAXL;
        if (v < WMINL) return WMINL;
        return v;
    endfunction

    function automatic longint sign_clamp(input logic [127:0] m, input bit neg);
        logic [127:0] lim;
        lim = neg ? 128'd2147483648 : 128'd2147483647;
        if (m > lim) m = lim;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        logic [127:0] ua, ub, p;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        p = ua * ub + (128'd1 << (FRAC_BITS - 1));
        return sign_clamp(p >> FRAC_BITS, (a < 0) != (b < 0));
    endfunction

    function automatic longint fx_div(input longint n, input longint d);
        logic [127:0] un;
        un = (n < 0) ? -n : n;
        return sign_clamp((un << FRAC_BITS) / d, n < 0);
    endfunction

    function automatic estimate_t filter_update(input logic signed [31:0] z_in,
                                                input logic [18:0] dt_in);
        longint z, dt, xp0, xp1, ap00, ap01, ap10, ap11, pp00, pp01, pp10, pp11;
        longint y, s, k0, k1;
        estimate_t e;
        z = z_in;
        dt = dt_in;
        k0 = 0;
        k1 = 0;
        xp0 = clamp(pos_est + fx_mul(dt, vel_est));
        xp1 = vel_est;
        ap00 = clamp(cov[0] + fx_mul(dt, cov[2]));
        ap01 = clamp(cov[1] + fx_mul(dt, cov[3]));
        ap10 = cov[2];
        ap11 = cov[3];
        pp00 = clamp(clamp(ap00 + fx_mul(ap01, dt)) + q_pos);
        pp01 = ap01;
        pp10 = clamp(ap10 + fx_mul(ap11, dt));
        pp11 = clamp(ap11 + q_vel);
        y = clamp(z - xp0);
        s = clamp(pp00 + r_meas);
        // gain stays zero when the innovation variance is not positive
        if (s > 0) begin
            k0 = fx_div(pp00, s);
            k1 = fx_div(pp10, s);
        end
        pos_est = clamp(xp0 + fx_mul(k0, y));
        vel_est = clamp(xp1 + fx_mul(k1, y));
        cov[0] = clamp(pp00 - fx_mul(k0, pp00));
        cov[1] = clamp(pp01 - fx_mul(k0, pp01));
        cov[2] = clamp(pp10 - fx_mul(k1, pp00));
        cov[3] = clamp(pp11 - fx_mul(k1, pp01));
        e.altitude = pos_est[31:0];
        e.climb_rate = vel_est[31:0];
        return e;
    endfunction

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk) cycles <= cycles + 1;

    always @(posedge clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // output side: random stalls, a calm stretch, and one long hold-off
    always @(negedge clk) begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_output)
            out_ch.ready <= 1'b0;
        else if (out_stall_on)
            out_ch.ready <= ($urandom_range(99) >= 26);
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk) begin
        estimate_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            estimates_seen <= estimates_seen + 1;
            if (expected_estimates.size() == 0) begin
                $display("%0t unexpected estimate alt=%h rate=%h", $time,
                         out_ch.altitude_estimate, out_ch.climb_rate_estimate);
                errors++;
            end else begin
                want = expected_estimates.pop_front();
                if (out_ch.altitude_estimate !== want.altitude) begin
                    $display("%0t altitude expected %h actual %h", $time,
                             want.altitude, out_ch.altitude_estimate);
                    errors++;
                end
                if (out_ch.climb_rate_estimate !== want.climb_rate) begin
                    $display("%0t climb rate expected %h actual %h", $time,
                             want.climb_rate, out_ch.climb_rate_estimate);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(input logic [IDX_WIDTH-1:0] idx,
                             input logic [CFG_WIDTH-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_QP: q_pos = val;
            REG_QV: q_vel = val;
            REG_R:  r_meas = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (expected_estimates.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Offer one measurement; the expectation is queued at the transfer edge.
    task automatic send_update(input logic signed [31:0] z, input logic [18:0] dt,
                               input bit known, input estimate_t est, input bit gaps);
        estimate_t e;
        @(negedge clk);
        while (gaps && $urandom_range(99) < 26) @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.altitude_measurement <= z;
        in_ch.time_step <= dt;
        do @(posedge clk); while (!in_ch.ready);
        e = filter_update(z, dt);
        if (known && e !== est) begin
            $display("%0t predictor disagrees with table: expected %h actual %h",
                     $time, est, e);
            errors++;
        end
        expected_estimates.push_back(e);
        updates_sent++;
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    function automatic logic [18:0] pick_dt();
        case ($urandom_range(9))
            0: return 19'd0;
            1: return 19'd262144;
            2: return 19'($urandom_range(262144));
            default: return 19'($urandom_range(6554, 1311));
        endcase
    endfunction

    function automatic logic signed [31:0] pick_altitude(input longint track);
        case ($urandom_range(9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom();
            default: return 32'(clamp(track + $signed(32'($urandom_range(131072))) - 65536));
        endcase
    endfunction

    vector_t directed [$];
    estimate_t none;

    initial begin
        logic signed [31:0] z;
        longint track;
        errors = 0;
        updates_sent = 0;
        estimates_seen = 0;
        cycles = 0;
        out_stall_on = 1'b1;
        hold_output = 1'b0;
        none = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_QP;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.altitude_measurement = '0;
        in_ch.time_step = '0;
        out_ch.ready = 1'b0;
        pos_est = 0;
        vel_est = 0;
        cov[0] = 65536; cov[1] = 0; cov[2] = 0; cov[3] = 65536;
        q_pos = 655; q_vel = 6554; r_meas = 65536;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // after reset, a zero measurement with zero dt leaves the state at zero
        directed.push_back('{32'sd0, 19'd0, 1'b1, '{32'sd0, 32'sd0}});
        directed.push_back('{32'sd65536, 19'd65536, 1'b0, none});
        directed.push_back('{32'sh7fffffff, 19'd262144, 1'b0, none});
        directed.push_back('{32'sh80000000, 19'd262144, 1'b0, none});
        directed.push_back('{32'sh7fffffff, 19'd0, 1'b0, none});
        directed.push_back('{32'sh80000000, 19'd1, 1'b0, none});
        directed.push_back('{32'shffffffff, 19'h7ffff, 1'b0, none});
        directed.push_back('{32'sh55555555, 19'h2aaaa, 1'b0, none});
        directed.push_back('{32'shaaaaaaaa, 19'h55555, 1'b0, none});
        foreach (directed[i])
            send_update(directed[i].z, directed[i].dt, directed[i].known,
                        directed[i].est, 1'b0);
        wait_idle();

        // register extremes; unknown index must be ignored
        write_reg(REG_QP, 31'h7fffffff);
        write_reg(REG_QV, 31'h7fffffff);
        write_reg(REG_R, 31'h7fffffff);
        write_reg(2'd3, 31'h12345);
        for (int i = 0; i < 4; i++)
            send_update($urandom(), pick_dt(), 1'b0, none, 1'b0);
        wait_idle();
        // zero noise: the innovation variance can reach zero or go negative
        write_reg(REG_QP, 31'd0);
        write_reg(REG_QV, 31'd0);
        write_reg(REG_R, 31'd0);
        for (int i = 0; i < 8; i++)
            send_update(32'sd0, 19'd0, 1'b0, none, 1'b0);
        for (int i = 0; i < 4; i++)
            send_update($urandom(), 19'h7ffff, 1'b0, none, 1'b0);
        wait_idle();

        track = pos_est;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 200 == 0) begin
                wait_idle();
                case ((n / 200) % 3)
                    0: begin
                        write_reg(REG_QP, 31'd655);
                        write_reg(REG_QV, 31'd6554);
                        write_reg(REG_R, 31'd65536);
                    end
                    1: begin
                        write_reg(REG_QP, 31'($urandom_range(65536)));
                        write_reg(REG_QV, 31'($urandom_range(65536)));
                        write_reg(REG_R, 31'($urandom_range(1 << 20)));
                    end
                    default: begin
                        write_reg(REG_QP, 31'($urandom()));
                        write_reg(REG_QV, 31'($urandom()));
                        write_reg(REG_R, 31'($urandom()));
                    end
                endcase
            end
            // calm stretch with no idling on either side
            out_stall_on = !(n >= 400 && n < 500);
            if (n == 600) begin
                // long hold-off at the output while measurements keep coming
                fork
                    begin
                        @(negedge clk);
                        hold_output = 1'b1;
                        repeat (600) @(posedge clk);
                        @(negedge clk);
                        hold_output = 1'b0;
                    end
                join_none
            end
            if (n == 800) wait_idle();
            z = pick_altitude(track);
            track = z;
            send_update(z, pick_dt(), 1'b0, none, out_stall_on);
        end

        wait_idle();
        $display("sent %0d measurements, checked %0d estimates across noise settings",
                 updates_sent, estimates_seen);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

FILE: filelist.f
sv/akf_pkg.sv
sv/akf_if.sv
sv/akf_mul.sv
sv/akf_div.sv
sv/altitude_kalman_filter_2state_core.sv
sim/akf_tb_if.sv
sim/tb.sv
